>>> rtl/psrl_pkg.sv
`timescale 1ns / 1ps
package psrl_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam int ADDR_W   = 32;
  localparam int HANDLE_W = 10;
  localparam int TIME_W   = 32;
  localparam int QUOTA_W  = 8;
  localparam int WINDOW_W = 16;
  localparam int CFG_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;

  localparam logic [QUOTA_W-1:0]  QUOTA_RESET  = 8'd10;
  localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd900;

  localparam logic OP_CONNECT = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_QUOTA  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 1'b1;

  typedef struct packed {
    logic [ADDR_W-1:0]   address;
    logic [HANDLE_W-1:0] handle;
    logic [TIME_W-1:0]   window_start;
    logic [QUOTA_W-1:0]  quota;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic             latch;
    logic             scan_rd;
    logic [IDX_W-1:0] rd_idx;
    logic             finish;
  } cmd_t;

  typedef struct packed {
    logic out_stall;
  } stat_t;

endpackage

>>> rtl/psrl_ctrl.sv
`timescale 1ns / 1ps
module psrl_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  psrl_pkg::stat_t stat,
  output psrl_pkg::cmd_t  cmd
);

  psrl_pkg::state_t state, state_next;
  logic [psrl_pkg::IDX_W-1:0] cnt;

  localparam logic [psrl_pkg::IDX_W-1:0] LAST_IDX =
    psrl_pkg::IDX_W'(psrl_pkg::TABLE_DEPTH - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psrl_pkg::ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == psrl_pkg::ST_IDLE) begin
        cnt <= '0;
      end else if (state == psrl_pkg::ST_SCAN) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      psrl_pkg::ST_IDLE: begin
        if (in_valid) state_next = psrl_pkg::ST_SCAN;
      end
      psrl_pkg::ST_SCAN: begin
        if (cnt == LAST_IDX) state_next = psrl_pkg::ST_LAST;
      end
      psrl_pkg::ST_LAST: begin
        state_next = psrl_pkg::ST_FINISH;
      end
      psrl_pkg::ST_FINISH: begin
        if (!stat.out_stall) state_next = psrl_pkg::ST_IDLE;
      end
      default: begin
        state_next = psrl_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    cmd.latch   = 1'b0;
    cmd.scan_rd = 1'b0;
    cmd.rd_idx  = cnt;
    cmd.finish  = 1'b0;
    case (state)
      psrl_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      psrl_pkg::ST_SCAN: begin
        cmd.scan_rd = 1'b1;
      end
      psrl_pkg::ST_LAST: begin
      end
      psrl_pkg::ST_FINISH: begin
        cmd.finish = !stat.out_stall;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> rtl/psrl_datapath.sv
`timescale 1ns / 1ps
module psrl_datapath (
  input  logic                                clk,
  input  logic                                rst,
  input  psrl_pkg::cmd_t                      cmd,
  output psrl_pkg::stat_t                     stat,
  input  logic [psrl_pkg::IN_DATA_W-1:0]      in_data,
  input  logic                                in_op,
  input  logic                                cfg_wr_en,
  input  logic [psrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psrl_pkg::CFG_W-1:0]          cfg_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [psrl_pkg::OUT_DATA_W-1:0]     out_data
);

  logic [psrl_pkg::QUOTA_W-1:0]  quota_per_window;
  logic [psrl_pkg::WINDOW_W-1:0] window_length;

  logic                          op;
  logic [psrl_pkg::ADDR_W-1:0]   addr;
  logic [psrl_pkg::HANDLE_W-1:0] handle;
  logic [psrl_pkg::TIME_W-1:0]   now;

  psrl_pkg::entry_t mem [psrl_pkg::TABLE_DEPTH];
  psrl_pkg::entry_t rd_data;
  logic [psrl_pkg::TABLE_DEPTH-1:0] entry_valid;

  logic                       proc_en;
  logic [psrl_pkg::IDX_W-1:0] proc_idx;
  logic                       matched;
  logic                       allowed;
  logic                       full;

  logic                         out_allowed;
  logic                         out_full;

  logic                         wr_en;
  logic [psrl_pkg::IDX_W-1:0]   wr_idx;
  psrl_pkg::entry_t             wr_data;

  logic [psrl_pkg::TIME_W-1:0]  elapsed;
  logic                         expired;
  logic [psrl_pkg::TIME_W-1:0]  start_n;
  logic [psrl_pkg::QUOTA_W-1:0] quota_n;
  logic                         ent_valid;
  logic                         hit;
  logic                         quota_left;
  psrl_pkg::entry_t             upd;

  logic                         any_free;
  logic [psrl_pkg::IDX_W-1:0]   free_idx;
  logic                         do_insert;

  // config
  always_ff @(posedge clk) begin
    if (rst) begin
      quota_per_window <= psrl_pkg::QUOTA_RESET;
      window_length    <= psrl_pkg::WINDOW_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        psrl_pkg::CFG_QUOTA:  quota_per_window <= cfg_data[psrl_pkg::QUOTA_W-1:0];
        psrl_pkg::CFG_WINDOW: window_length    <= cfg_data[psrl_pkg::WINDOW_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // refill check and match on the entry read last cycle
  always_comb begin
    ent_valid  = entry_valid[proc_idx];
    elapsed    = now - rd_data.window_start;
    expired    = elapsed > {{(psrl_pkg::TIME_W-psrl_pkg::WINDOW_W){1'b0}}, window_length};
    start_n    = expired ? now : rd_data.window_start;
    quota_n    = expired ? quota_per_window : rd_data.quota;
    quota_left = quota_n != '0;
    if (op == psrl_pkg::OP_CONNECT) begin
      hit = ent_valid && !matched && (rd_data.address == addr);
    end else begin
      hit = ent_valid && !matched && (rd_data.handle == handle);
    end
    upd.address      = rd_data.address;
    upd.handle       = (hit && op == psrl_pkg::OP_CONNECT) ? handle : rd_data.handle;
    upd.window_start = start_n;
    upd.quota        = (hit && op == psrl_pkg::OP_REQUEST && quota_left) ?
                       quota_n - 1'b1 : quota_n;
  end

  // lowest free entry
  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int k = psrl_pkg::TABLE_DEPTH - 1; k >= 0; k--) begin
      if (!entry_valid[k]) begin
        any_free = 1'b1;
        free_idx = psrl_pkg::IDX_W'(k);
      end
    end
  end

  assign do_insert = cmd.finish && (op == psrl_pkg::OP_CONNECT) && !matched && any_free;

  always_comb begin
    wr_en   = 1'b0;
    wr_idx  = proc_idx;
    wr_data = upd;
    if (do_insert) begin
      wr_en                = 1'b1;
      wr_idx               = free_idx;
      wr_data.address      = addr;
      wr_data.handle       = handle;
      wr_data.window_start = now;
      wr_data.quota        = quota_per_window;
    end else if (proc_en && ent_valid) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_idx] <= wr_data;
    if (cmd.scan_rd) rd_data <= mem[cmd.rd_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      proc_en     <= 1'b0;
    end else begin
      proc_en <= cmd.scan_rd;
      if (do_insert) entry_valid[free_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    proc_idx <= cmd.rd_idx;
    if (cmd.latch) begin
      op      <= in_op;
      addr    <= in_data[31:0];
      handle  <= in_data[41:32];
      now     <= in_data[73:42];
      matched <= 1'b0;
      allowed <= 1'b1;
    end else if (proc_en) begin
      matched <= matched | hit;
      if (hit && op == psrl_pkg::OP_REQUEST) allowed <= quota_left;
    end
  end

  always_comb begin
    full = (op == psrl_pkg::OP_CONNECT) && !matched && !any_free;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_allowed <= (op == psrl_pkg::OP_CONNECT) ? 1'b1 : allowed;
      out_full    <= full;
    end
  end

  assign stat.out_stall = out_valid && !out_ready;
  assign out_data = {{(psrl_pkg::OUT_DATA_W-2){1'b0}}, out_full, out_allowed};

endmodule

>>> rtl/per_source_request_rate_limiter.sv
`timescale 1ns / 1ps
// Fixed-window per-source rate limiter over a table of TABLE_DEPTH sources. Connect events
// (s_tuser = 0) register a source address with a connection handle; request events
// (s_tuser = 1) spend one unit of the owning source's quota and report allowed or denied.
// Each event first refills every entry whose window has run out. One event is handled at a
// time, and the pace is set by the single scan of the entry table that does refill and
// lookup together, reading one entry and writing back the previous one each cycle. A
// finished result sits in an output register, so the next event can be taken while it
// waits. Configuration writes must go in only while the block is idle; the block itself
// does not enforce this.
module per_source_request_rate_limiter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // source_address[31:0], connection_handle[41:32], event time[73:42], zero pad
  input  logic [psrl_pkg::IN_DATA_W-1:0]      s_tdata,
  // operation[0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // allowed[0], table_full[1], zero pad
  output logic [psrl_pkg::OUT_DATA_W-1:0]     m_tdata,
  input  logic                                cfg_wr_en,
  input  logic [psrl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [psrl_pkg::CFG_W-1:0]          cfg_data
);

  psrl_pkg::cmd_t  cmd;
  psrl_pkg::stat_t stat;

  psrl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  psrl_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_data   (s_tdata),
    .in_op     (s_tuser),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

  a_no_accept_in_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.scan_rd |-> !s_tready)
    else $error("input accepted during table scan");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second transaction accepted before scan");

  a_finish_loads_out: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> m_tvalid)
    else $error("finished result not presented");

  a_finish_not_on_stall: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !(m_tvalid && !m_tready))
    else $error("result overwrites a stalled result");

endmodule

>>> dv/tb_per_source_request_rate_limiter.sv
`timescale 1ns / 1ps
module tb_per_source_request_rate_limiter;
  import psrl_pkg::*;

  localparam int PHASES          = 8;
  localparam int EVENTS_PER_PHASE = 216;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int HANDLE_POOL     = 24;

  typedef struct packed {
    logic table_full;
    logic allowed;
  } verdict_t;

  typedef enum logic {ROW_EVENT, ROW_CONFIG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic                  op;
    logic [HANDLE_W-1:0]   hdl;
    logic [ADDR_W-1:0]     addr;
    logic [TIME_W-1:0]     now;
    logic                  typed;
    logic                  allowed;
    logic                  full;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_W-1:0]      cfg_val;
  } dir_row_t;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tuser;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_W-1:0]      cfg_data;

  // shadow of the source table and registers
  bit                    tbl_valid [TABLE_DEPTH];
  logic [ADDR_W-1:0]     tbl_addr  [TABLE_DEPTH];
  logic [HANDLE_W-1:0]   tbl_hdl   [TABLE_DEPTH];
  logic [TIME_W-1:0]     tbl_start [TABLE_DEPTH];
  logic [QUOTA_W-1:0]    tbl_quota [TABLE_DEPTH];
  logic [QUOTA_W-1:0]    quota_cfg  = QUOTA_RESET;
  logic [WINDOW_W-1:0]   window_cfg = WINDOW_RESET;

  verdict_t pending_verdicts[$];

  int src_idle_pct  = 0;
  int sink_stall_pct = 0;
  int mismatches    = 0;
  int events_sent   = 0;
  int connects_sent = 0;
  int verdicts_seen = 0;
  int denials       = 0;
  int full_hits     = 0;
  int idle_cycles   = 0;

  logic [QUOTA_W-1:0]  phase_quota  [PHASES] = '{8'd255, 8'd0, 8'd3, 8'd10, 8'd1, 8'd7, 8'd255, 8'd0};
  logic [WINDOW_W-1:0] phase_window [PHASES] = '{16'hFFFF, 16'd0, 16'd5, 16'd900, 16'd1, 16'd30,
                                                 16'd0, 16'hFFFF};

  dir_row_t directed_rows [30] = '{
    '{ROW_EVENT,  OP_REQUEST, 'h000, 'h0000_0000, 100,          1, 1, 0, CFG_QUOTA,  0},
    '{ROW_CONFIG, OP_CONNECT, 'h000, 'h0000_0000, 0,            0, 0, 0, CFG_QUOTA,  1},
    '{ROW_EVENT,  OP_CONNECT, 'h000, 'h0000_0000, 100,          1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_REQUEST, 'h000, 'h0000_0000, 100,          1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_REQUEST, 'h000, 'h0000_0000, 100,          1, 0, 0, CFG_QUOTA,  0},
    '{ROW_CONFIG, OP_CONNECT, 'h000, 'h0000_0000, 0,            0, 0, 0, CFG_WINDOW, 0},
    '{ROW_EVENT,  OP_REQUEST, 'h000, 'h0000_0000, 101,          0, 0, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h3FF, 'hFFFF_FFFF, 'hFFFF_FFFF,  1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h3FF, 'h0000_0000, 'hFFFF_FFFF,  1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_REQUEST, 'h3FF, 'h0000_0000, 'hFFFF_FFFF,  0, 0, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_REQUEST, 'h3FF, 'h0000_0000, 'hFFFF_FFFF,  0, 0, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_REQUEST, 'h3FF, 'h0000_0000, 0,            0, 0, 0, CFG_QUOTA,  0},
    '{ROW_CONFIG, OP_CONNECT, 'h000, 'h0000_0000, 0,            0, 0, 0, CFG_QUOTA,  'hFFFF},
    '{ROW_CONFIG, OP_CONNECT, 'h000, 'h0000_0000, 0,            0, 0, 0, CFG_WINDOW, 'hFFFF},
    '{ROW_EVENT,  OP_CONNECT, 'h001, 'h0000_0001, 1,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h002, 'h8000_0000, 2,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h004, 'h5555_5555, 3,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h008, 'hAAAA_AAAA, 4,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h010, 'h0F0F_0F0F, 5,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h020, 'hF0F0_F0F0, 6,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h040, 'h0000_FFFF, 7,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h080, 'hFFFF_0000, 8,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h100, 'h0102_0304, 9,            1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h200, 'hC0A8_0001, 10,           1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h2AA, 'h0A00_0001, 11,           1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h0F0, 'h7FFF_FFFF, 12,           1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h30F, 'hFFFF_FFFE, 13,           1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h1FF, 'h0000_0002, 14,           1, 1, 0, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_CONNECT, 'h155, 'h1234_5678, 14,           1, 1, 1, CFG_QUOTA,  0},
    '{ROW_EVENT,  OP_REQUEST, 'h3C3, 'h0000_0000, 14,           1, 1, 0, CFG_QUOTA,  0}
  };

  per_source_request_rate_limiter uut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // refill expired windows, then apply the event to the shadow table
  function automatic verdict_t rate_decision(input logic op, input logic [ADDR_W-1:0] addr,
                                             input logic [HANDLE_W-1:0] hdl,
                                             input logic [TIME_W-1:0] now);
    verdict_t v;
    logic [TIME_W-1:0] elapsed;
    int k;
    bit done;
    v.allowed = 1'b1;
    v.table_full = 1'b0;
    done = 0;
    for (k = 0; k < TABLE_DEPTH; k++) begin
      if (tbl_valid[k]) begin
        elapsed = now - tbl_start[k];
        if (elapsed > TIME_W'(window_cfg)) begin
          tbl_start[k] = now;
          tbl_quota[k] = quota_cfg;
        end
      end
    end
    if (op == OP_CONNECT) begin
      for (k = 0; k < TABLE_DEPTH && !done; k++) begin
        if (tbl_valid[k] && tbl_addr[k] == addr) begin
          tbl_hdl[k] = hdl;
          done = 1;
        end
      end
      for (k = 0; k < TABLE_DEPTH && !done; k++) begin
        if (!tbl_valid[k]) begin
          tbl_valid[k] = 1;
          tbl_addr[k]  = addr;
          tbl_hdl[k]   = hdl;
          tbl_start[k] = now;
          tbl_quota[k] = quota_cfg;
          done = 1;
        end
      end
      v.table_full = !done;
    end else begin
      for (k = 0; k < TABLE_DEPTH && !done; k++) begin
        if (tbl_valid[k] && tbl_hdl[k] == hdl) begin
          done = 1;
          if (tbl_quota[k] != '0) tbl_quota[k] = tbl_quota[k] - 1'b1;
          else v.allowed = 1'b0;
        end
      end
    end
    return v;
  endfunction

  task automatic send_event(input logic op, input logic [ADDR_W-1:0] addr,
                            input logic [HANDLE_W-1:0] hdl, input logic [TIME_W-1:0] now,
                            input logic use_typed, input verdict_t typed_v);
    verdict_t v;
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {6'b0, now, hdl, addr};
    do @(posedge clk); while (!s_tready);
    v = rate_decision(op, addr, hdl, now);
    pending_verdicts.insert(pending_verdicts.size(), use_typed ? typed_v : v);
    events_sent++;
    if (op == OP_CONNECT) connects_sent++;
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_QUOTA) quota_cfg = val[QUOTA_W-1:0];
    else window_cfg = val[WINDOW_W-1:0];
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin : verdict_check
    verdict_t want;
    if (!rst && m_tvalid && m_tready) begin
      verdicts_seen++;
      if (pending_verdicts.size() == 0) begin
        report_mismatch($sformatf("unexpected result tdata=%0h", m_tdata));
      end else begin
        want = pending_verdicts.pop_front();
        if (m_tdata[0] !== want.allowed)
          report_mismatch($sformatf("allowed %b, expected %b", m_tdata[0], want.allowed));
        if (m_tdata[1] !== want.table_full)
          report_mismatch($sformatf("table_full %b, expected %b", m_tdata[1], want.table_full));
        if (m_tdata[OUT_DATA_W-1:2] !== '0)
          report_mismatch($sformatf("pad bits %b not zero", m_tdata[OUT_DATA_W-1:2]));
        if (!want.allowed) denials++;
        if (want.table_full) full_hits++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : stimulus
    verdict_t            tv;
    logic [TIME_W-1:0]   now_time;
    logic [ADDR_W-1:0]   addr;
    logic [HANDLE_W-1:0] hdl;
    logic                op;
    int                  r, ph, n, pick, slot;
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (r = 0; r < $size(directed_rows); r++) begin
      if (directed_rows[r].kind == ROW_CONFIG) begin
        drain_results();
        write_reg(directed_rows[r].cfg_idx, directed_rows[r].cfg_val);
      end else begin
        tv.allowed    = directed_rows[r].allowed;
        tv.table_full = directed_rows[r].full;
        send_event(directed_rows[r].op, directed_rows[r].addr, directed_rows[r].hdl,
                   directed_rows[r].now, directed_rows[r].typed, tv);
      end
    end

    now_time = 32'd20;
    tv = '0;
    for (ph = 0; ph < PHASES; ph++) begin
      drain_results();
      write_reg(CFG_QUOTA, {8'($urandom), phase_quota[ph]});
      write_reg(CFG_WINDOW, phase_window[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 69; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 69; end
        default: begin src_idle_pct = 9; sink_stall_pct = 9; end
      endcase
      for (n = 0; n < EVENTS_PER_PHASE; n++) begin
        if (n == EVENTS_PER_PHASE / 2) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 70) now_time = now_time + $urandom_range(0, 2);
        else if (pick < 85) now_time = now_time + window_cfg + $urandom_range(0, 1);
        else if (pick < 95) now_time = now_time + $urandom_range(0, window_cfg);
        else now_time = $urandom;
        if ($urandom_range(0, 99) < 85) hdl = HANDLE_W'($urandom_range(0, HANDLE_POOL - 1));
        else hdl = HANDLE_W'($urandom);
        if ($urandom_range(0, 99) < 75) begin
          op = OP_REQUEST;
          addr = $urandom;
        end else begin
          op = OP_CONNECT;
          slot = $urandom_range(0, TABLE_DEPTH - 1);
          if ($urandom_range(0, 99) < 70 && tbl_valid[slot]) addr = tbl_addr[slot];
          else addr = $urandom;
        end
        send_event(op, addr, hdl, now_time, 1'b0, tv);
      end
    end

    drain_results();
    repeat (2 * TABLE_DEPTH) @(posedge clk);
    $display("Sent %0d events (%0d connects, %0d requests) across %0d register settings",
             events_sent, connects_sent, events_sent - connects_sent, PHASES + 2);
    $display("Checked %0d results: %0d denied, %0d table-full, %0d mismatches",
             verdicts_seen, denials, full_hits, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
